>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
// SQK_ASSERT checks a property outside reset; SQK_ASSERT_RST checks it always.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define SQK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SQK_ASSERT_RST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/sqk_pkg.sv
// ----------------------------------------------------------------------------
// sqk_pkg
// Types, constants and the AES inverse S-box shared by the key byte test.
// ----------------------------------------------------------------------------
package sqk_pkg;

    localparam int SQK_GUESS_COUNT = 256;
    localparam int GUESS_W         = 8;
    localparam int POS_W           = 4;
    localparam int BYTE_W          = 8;

    // Item travelling down the chain, with the running best guess
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] cipher_a;
        logic [BYTE_W-1:0] cipher_b;
        logic [GUESS_W-1:0] best;
        logic              found;
    } token_t;

    localparam logic [7:0] INV_SBOX [0:255] = '{
        8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,
        8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
        8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,
        8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
        8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,
        8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
        8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,
        8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
        8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,
        8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
        8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,
        8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
        8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,
        8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
        8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,
        8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
        8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,
        8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
        8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,
        8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
        8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,
        8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
        8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,
        8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
        8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,
        8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
        8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,
        8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
        8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,
        8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
        8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,
        8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };

endpackage

>>> hw/rtl/sqk_cell.sv
// ----------------------------------------------------------------------------
// sqk_cell
// One key guess: accumulates both set sums and tests them on the last item.
// ----------------------------------------------------------------------------
module sqk_cell
    import sqk_pkg::*;
#(
    parameter logic [GUESS_W-1:0] GUESS = '0
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   advance,
    input  token_t tok_in,
    output token_t tok_out
);

    logic [BYTE_W-1:0] sum_a_reg, sum_a_next;
    logic [BYTE_W-1:0] sum_b_reg, sum_b_next;
    token_t            tok_reg, tok_next;
    logic              balanced;

    always_comb begin
        sum_a_next = sum_a_reg ^ INV_SBOX[tok_in.cipher_a ^ GUESS];
        sum_b_next = sum_b_reg ^ INV_SBOX[tok_in.cipher_b ^ GUESS];
        balanced   = (sum_a_next == '0) && (sum_b_next == '0);
        tok_next   = tok_in;
        // later cells overwrite, so the tail holds the greatest guess
        if (tok_in.valid && tok_in.last && balanced) begin
            tok_next.best  = GUESS;
            tok_next.found = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            tok_reg   <= '0;
        end else if (advance) begin
            tok_reg <= tok_next;
            if (tok_in.valid) begin
                if (tok_in.last) begin
                    sum_a_reg <= '0;
                    sum_b_reg <= '0;
                end else begin
                    sum_a_reg <= sum_a_next;
                    sum_b_reg <= sum_b_next;
                end
            end
        end
    end

    assign tok_out = tok_reg;

endmodule

>>> hw/rtl/square_attack_key_byte_test_core.sv
// ----------------------------------------------------------------------------
// square_attack_key_byte_test_core
// Square attack last-round key byte test: a chain of one cell per key guess.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle; the whole chain stalls while a result waits.
// Path: cell 0 takes a last item at its accepting edge, the item walks the
// cells in order, and the output register takes it from the last cell.
// Reset: aresetn clears all sums, the chain and the output valid flag at once;
// the output position, guess and found registers are not reset.
module square_attack_key_byte_test_core
    import sqk_pkg::*;
#(
    parameter int GUESS_COUNT = SQK_GUESS_COUNT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // byte_position[3:0], cipher_byte_a[11:4],
                                        // cipher_byte_b[19:12], zero[23:20]
    input  logic        s_axis_tlast,   // last_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // key_position[3:0], key_byte_guess[11:4],
                                        // zero[15:12]
    output logic [0:0]  m_axis_tuser    // guess_found[0]
);

    token_t             chain [0:GUESS_COUNT];
    logic               advance;
    logic               m_valid_reg;
    logic [POS_W-1:0]   m_pos_reg;
    logic [GUESS_W-1:0] m_guess_reg;
    logic               m_found_reg;

    // hold the chain while a result waits
    assign advance       = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    always_comb begin
        chain[0].valid    = s_axis_tvalid;
        chain[0].last     = s_axis_tlast;
        chain[0].pos      = s_axis_tdata[3:0];
        chain[0].cipher_a = s_axis_tdata[11:4];
        chain[0].cipher_b = s_axis_tdata[19:12];
        chain[0].best     = '0;
        chain[0].found    = 1'b0;
    end

    for (genvar g = 0; g < GUESS_COUNT; g++) begin : g_cell
        sqk_cell #(
            .GUESS (GUESS_W'(g))
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .advance (advance),
            .tok_in  (chain[g]),
            .tok_out (chain[g+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= chain[GUESS_COUNT].valid && chain[GUESS_COUNT].last;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_pos_reg   <= chain[GUESS_COUNT].pos;
            m_guess_reg <= chain[GUESS_COUNT].best;
            m_found_reg <= chain[GUESS_COUNT].found;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = {4'b0, m_guess_reg, m_pos_reg};
    assign m_axis_tuser[0] = m_found_reg;

endmodule

>>> hw/rtl/sqk_checker.sv
// ----------------------------------------------------------------------------
// sqk_checker
// Port-level checks on the key byte test core, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sqk_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    `SQK_ASSERT_RST(a_reset_clears_out, aclk,
        !aresetn |=> !m_axis_tvalid, "result after reset")

    `SQK_ASSERT(a_stall_blocks_in, aclk, aresetn,
        m_axis_tvalid && !m_axis_tready |-> !s_axis_tready,
        "input taken while result stalled")

    `SQK_ASSERT(a_no_find_zero_guess, aclk, aresetn,
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[11:4] == 8'h00,
        "guess set without find")

    `SQK_ASSERT(a_result_held, aclk, aresetn,
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata),
        "stalled result dropped")

endmodule

bind square_attack_key_byte_test_core sqk_checker u_sqk_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
